/* hw/rtl/hsl2rgb_pkg.sv */
// Shared types and constants for the HSL to RGB color converter.
package hsl2rgb_pkg;

    localparam int FRAC_BITS_DEF = 16;

    // Q1.16 full scale of the saturation and lightness inputs.
    localparam logic [16:0] IN_ONE = 17'h10000;
    localparam logic [7:0]  CH_MAX = 8'hFF;

    typedef struct packed {
        logic [15:0] hue;
        logic [16:0] saturation;
        logic [16:0] lightness;
    } hsl_in_t;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [23:0] packed_color;
    } rgb_out_t;

endpackage

/* hw/rtl/hsl_to_rgb_top.sv */
// HSL to RGB converter: six-stage pipeline, one transfer per clock on each side unless m_ready stalls it.
//
//  channel | ports                      | payload
//  --------+----------------------------+--------------------------------------
//  input   | s_valid, s_ready, s_data   | hue, saturation, lightness
//  result  | m_valid, m_ready, m_data   | red, green, blue, packed_color
//
// Each item passes through the six register stages in order; a new item can
// enter every cycle while the output is not stalled, so the rate is one item per clock.
// The stages are: input conversion, l*s product and hue segment, p and d,
// the three hue products, channel value, and the scale to 0..255 (output).
// Reset (aresetn low at a clock edge) empties all stages.
// A stall on m_ready holds only the stages that are full behind the output;
// empty stages still fill, so s_ready stays high while bubbles remain.
module hsl_to_rgb_top #(
    parameter int FRAC_BITS = hsl2rgb_pkg::FRAC_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  hsl2rgb_pkg::hsl_in_t  s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output hsl2rgb_pkg::rgb_out_t m_data
);

    localparam int W  = FRAC_BITS + 1;
    localparam int UP = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int DN = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
    localparam int XW = 17 + UP;
    localparam int HW = 16 + UP;
    localparam int LANES = 3;

    localparam logic [W-1:0] ONE     = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [W-1:0] HALF    = ONE >> 1;
    localparam logic [W-1:0] THIRD_W = ONE / 3;
    localparam logic [FRAC_BITS-1:0] THIRD = THIRD_W[FRAC_BITS-1:0];
    localparam logic [FRAC_BITS+2:0] ONE_X  = (FRAC_BITS + 3)'(ONE);
    localparam logic [FRAC_BITS+2:0] FOUR_X = ONE_X << 2;
    localparam logic [FRAC_BITS+1:0] TWO_Y  = (FRAC_BITS + 2)'(ONE) << 1;

    // Piece of the hue function that a lane falls in.
    typedef enum logic [1:0] {
        SEG_RISE,
        SEG_TOP,
        SEG_FALL,
        SEG_BASE
    } seg_t;

    // Stage enables: a stage loads when it is empty or its successor moves.
    logic en1, en2, en3, en4, en5, en6;

    logic vld1_reg, vld2_reg, vld3_reg, vld4_reg, vld5_reg, vld6_reg;

    // Stage 1: converted inputs and hue positions.
    logic [W-1:0]         l1_reg, s1_reg, l1_next, s1_next;
    logic                 achro1_reg, achro1_next;
    logic [FRAC_BITS-1:0] t1_reg [LANES];
    logic [FRAC_BITS-1:0] t1_next [LANES];
    logic [16:0]          sat_clamp, light_clamp;
    logic [XW-1:0]        sat_x, light_x;
    logic [HW-1:0]        hue_x;
    logic [FRAC_BITS-1:0] hue_int;

    // Stage 2: l*s product and hue segment with its multiplicand.
    logic [W-1:0]   l2_reg, s2_reg, ls2_reg, ls2_next;
    logic           achro2_reg, low2_reg, low2_next;
    logic [2*W-1:0] ls_full;
    seg_t           seg2_reg [LANES];
    seg_t           seg2_next [LANES];
    logic [W-1:0]   m2_reg [LANES];
    logic [W-1:0]   m2_next [LANES];
    logic [FRAC_BITS+2:0] six_t [LANES];
    logic [FRAC_BITS+1:0] three_t [LANES];
    logic [FRAC_BITS+2:0] fall_m [LANES];

    // Stage 3: p and d = q - p.
    logic [W-1:0] p3_reg, d3_reg, p3_next, d3_next, k_diff;
    seg_t         seg3_reg [LANES];
    logic [W-1:0] m3_reg [LANES];

    // Stage 4: hue products.
    logic [W-1:0]   p4_reg, d4_reg;
    seg_t           seg4_reg [LANES];
    logic [W-1:0]   prod4_reg [LANES];
    logic [W-1:0]   prod4_next [LANES];
    logic [2*W-1:0] prod_full [LANES];

    // Stage 5: channel values in fixed point.
    logic [W-1:0] v5_reg [LANES];
    logic [W-1:0] v5_next [LANES];
    logic [W:0]   v_sum [LANES];

    // Stage 6: output register.
    hsl2rgb_pkg::rgb_out_t out_reg, out_next;
    logic [W+7:0] scaled [LANES];
    logic [W+7:0] ch_wide [LANES];
    logic [7:0]   ch [LANES];

    assign en6 = !vld6_reg || m_ready;
    assign en5 = !vld5_reg || en6;
    assign en4 = !vld4_reg || en5;
    assign en3 = !vld3_reg || en4;
    assign en2 = !vld2_reg || en3;
    assign en1 = !vld1_reg || en2;

    assign s_ready = en1;
    assign m_valid = vld6_reg;
    assign m_data  = out_reg;

    // Input conversion to FRAC_BITS fraction bits, with clamp to 1.0.
    always_comb begin
        sat_clamp   = (s_data.saturation > hsl2rgb_pkg::IN_ONE) ?
                      hsl2rgb_pkg::IN_ONE : s_data.saturation;
        light_clamp = (s_data.lightness > hsl2rgb_pkg::IN_ONE) ?
                      hsl2rgb_pkg::IN_ONE : s_data.lightness;
        sat_x   = XW'(sat_clamp) << UP;
        light_x = XW'(light_clamp) << UP;
        hue_x   = HW'(s_data.hue) << UP;
        s1_next = W'(sat_x >> DN);
        l1_next = W'(light_x >> DN);
        hue_int = FRAC_BITS'(hue_x >> DN);
        achro1_next = (s1_next == '0);
        // Offsets by one third wrap modulo one turn through the width.
        t1_next[0] = hue_int + THIRD;
        t1_next[1] = hue_int;
        t1_next[2] = hue_int - THIRD;
    end

    // Product l*s and the hue segment tests of each lane.
    always_comb begin
        ls_full   = l1_reg * s1_reg;
        ls2_next  = W'(ls_full >> FRAC_BITS);
        low2_next = (l1_reg < HALF);
        for (int i = 0; i < LANES; i++) begin
            six_t[i]   = (FRAC_BITS + 3)'(t1_reg[i]) * (FRAC_BITS + 3)'(6);
            three_t[i] = (FRAC_BITS + 2)'(t1_reg[i]) + (FRAC_BITS + 2)'({t1_reg[i], 1'b0});
            fall_m[i]  = FOUR_X - six_t[i];
            if (six_t[i] < ONE_X) begin
                seg2_next[i] = SEG_RISE;
                m2_next[i]   = six_t[i][W-1:0];
            end else if (!t1_reg[i][FRAC_BITS-1]) begin
                seg2_next[i] = SEG_TOP;
                m2_next[i]   = '0;
            end else if (three_t[i] < TWO_Y) begin
                seg2_next[i] = SEG_FALL;
                m2_next[i]   = fall_m[i][W-1:0];
            end else begin
                seg2_next[i] = SEG_BASE;
                m2_next[i]   = '0;
            end
        end
    end

    // q - l is the l*s term below half lightness and s - l*s above it,
    // so p = l - (q - l) and d = 2(q - l). The gray case forces p = l, d = 0.
    always_comb begin
        k_diff = low2_reg ? ls2_reg : (s2_reg - ls2_reg);
        if (achro2_reg) begin
            p3_next = l2_reg;
            d3_next = '0;
        end else begin
            p3_next = l2_reg - k_diff;
            d3_next = W'({k_diff, 1'b0});
        end
    end

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            prod_full[i]  = d3_reg * m3_reg[i];
            prod4_next[i] = W'(prod_full[i] >> FRAC_BITS);
        end
    end

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            case (seg4_reg[i])
                SEG_RISE: v_sum[i] = {1'b0, p4_reg} + {1'b0, prod4_reg[i]};
                SEG_TOP:  v_sum[i] = {1'b0, p4_reg} + {1'b0, d4_reg};
                SEG_FALL: v_sum[i] = {1'b0, p4_reg} + {1'b0, prod4_reg[i]};
                SEG_BASE: v_sum[i] = {1'b0, p4_reg};
                default:  v_sum[i] = {1'b0, p4_reg};
            endcase
            v5_next[i] = W'(v_sum[i]);
        end
    end

    // Times 255 as a shift and subtract, then truncate and clamp.
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            scaled[i]  = (W + 8)'({v5_reg[i], 8'h00}) - (W + 8)'(v5_reg[i]);
            ch_wide[i] = scaled[i] >> FRAC_BITS;
            ch[i]      = (ch_wide[i] > (W + 8)'(hsl2rgb_pkg::CH_MAX)) ?
                         hsl2rgb_pkg::CH_MAX : ch_wide[i][7:0];
        end
        out_next.red          = ch[0];
        out_next.green        = ch[1];
        out_next.blue         = ch[2];
        out_next.packed_color = {ch[0], ch[1], ch[2]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
            vld5_reg <= 1'b0;
            vld6_reg <= 1'b0;
        end else begin
            if (en1) vld1_reg <= s_valid;
            if (en2) vld2_reg <= vld1_reg;
            if (en3) vld3_reg <= vld2_reg;
            if (en4) vld4_reg <= vld3_reg;
            if (en5) vld5_reg <= vld4_reg;
            if (en6) vld6_reg <= vld5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            l1_reg     <= l1_next;
            s1_reg     <= s1_next;
            achro1_reg <= achro1_next;
            t1_reg     <= t1_next;
        end
        if (en2) begin
            l2_reg     <= l1_reg;
            s2_reg     <= s1_reg;
            achro2_reg <= achro1_reg;
            low2_reg   <= low2_next;
            ls2_reg    <= ls2_next;
            seg2_reg   <= seg2_next;
            m2_reg     <= m2_next;
        end
        if (en3) begin
            p3_reg   <= p3_next;
            d3_reg   <= d3_next;
            seg3_reg <= seg2_reg;
            m3_reg   <= m2_reg;
        end
        if (en4) begin
            p4_reg    <= p3_reg;
            d4_reg    <= d3_reg;
            seg4_reg  <= seg3_reg;
            prod4_reg <= prod4_next;
        end
        if (en5) begin
            v5_reg <= v5_next;
        end
        if (en6) begin
            out_reg <= out_next;
        end
    end

    // The packed color always agrees with the separate channels.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.packed_color == {m_data.red, m_data.green, m_data.blue}))
        else $error("packed_color does not match red, green and blue");

    // A free output stage must never block the input side.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (!vld6_reg || m_ready) |-> s_ready)
        else $error("input stalled while the pipeline can advance");

    // q = p + d never exceeds one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        vld3_reg |-> (({1'b0, p3_reg} + {1'b0, d3_reg}) <= {1'b0, ONE}))
        else $error("q exceeds one");

    // An accepted transfer always occupies the first stage next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> vld1_reg)
        else $error("accepted transfer lost at stage one");

endmodule
